### sv/range_sensor_noise_model_core_assert.svh
// ----------------------------------------------------------------------------
// range sensor noise model assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef RANGE_SENSOR_NOISE_MODEL_CORE_ASSERT_SVH
`define RANGE_SENSOR_NOISE_MODEL_CORE_ASSERT_SVH

// same-cycle implication, quiet while reset is applied
`define RSNM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsnm port check failed");

// next-cycle implication, quiet while reset is applied
`define RSNM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsnm port check failed");

`endif

### sv/rsnm_pkg.sv
// ----------------------------------------------------------------------------
// rsnm_pkg
// types, register codes and fixed-point coefficients of the range noise model
// ----------------------------------------------------------------------------
`default_nettype none

package rsnm_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_TYPE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_DIMS  = 4'd1;

  // sensor type codes
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_LASER0 = 3'd0;
  localparam logic [ST_W-1:0] ST_LASER1 = 3'd1;
  localparam logic [ST_W-1:0] ST_LASER2 = 3'd2;
  localparam logic [ST_W-1:0] ST_DEPTH  = 3'd3;
  localparam logic [ST_W-1:0] ST_LASER4 = 3'd4;
  localparam logic [ST_W-1:0] ST_RESET  = ST_LASER0;

  // point dimension codes
  localparam int DIMS_W = 2;
  localparam logic [DIMS_W-1:0] DIMS_2D    = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QLVL_W = 3;

  // coefficient widths, values scaled by 2^32
  localparam int MIN_W   = 27;
  localparam int ANG_W   = 25;
  localparam int CST_W   = 28;
  localparam int DCOEF_W = 23;
  localparam logic [DCOEF_W-1:0] DEPTH_COEF = 23'd6120328;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
  } in_item_t;

  typedef struct packed {
    logic [31:0] noise_value;
    logic        saturated;
  } out_item_t;

  // item class decided at the front
  typedef struct packed {
    logic            is_laser;
    logic            is_depth;
    logic [ST_W-1:0] sel;
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } qstat_t;

  function automatic cls_t classify(input logic [ST_W-1:0] stype);
    cls_t c;
    c.sel      = stype;
    c.is_laser = 1'b0;
    c.is_depth = 1'b0;
    case (stype)
      ST_LASER0, ST_LASER1, ST_LASER2, ST_LASER4: c.is_laser = 1'b1;
      ST_DEPTH:                                   c.is_depth = 1'b1;
      default:                                    c.sel      = ST_RESET;
    endcase
    return c;
  endfunction

  function automatic logic [MIN_W-1:0] laser_min(input logic [ST_W-1:0] sel);
    logic [MIN_W-1:0] v;
    case (sel)
      ST_LASER0: v = 27'd51539608;
      ST_LASER1: v = 27'd120259084;
      ST_LASER2: v = 27'd77309411;
      ST_LASER4: v = 27'd17179869;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [ANG_W-1:0] laser_ang(input logic [ST_W-1:0] sel);
    logic [ANG_W-1:0] v;
    case (sel)
      ST_LASER0: v = 25'd29205778;
      ST_LASER1: v = 25'd5583457;
      ST_LASER2: v = 25'd2576980;
      ST_LASER4: v = 25'd22763327;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CST_W-1:0] laser_cst(input logic [ST_W-1:0] sel);
    logic signed [CST_W-1:0] v;
    case (sel)
      ST_LASER0: v = 28'sd3435974;
      ST_LASER1: v = 28'sd429497;
      ST_LASER2: v = 28'sd6442451;
      ST_LASER4: v = -28'sd39513699;
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/range_sensor_noise_model_core.sv
// Path: an accepted point passes front stages 1 and 2, the queue, the square
// root stages (one result bit each) and the tail registers to out_valid.
// Throughput: one point per cycle; the back end never stalls, so busy stays
// low outside reset and the four-entry queue never holds more than one item.
// Reset: synchronous, active low; clears all valid state, sensor_type to 0
// and point_dims to 3. Config writes are taken in every cycle.
// ----------------------------------------------------------------------------
// range_sensor_noise_model_core
// per-point range noise: laser line fit or depth camera quadratic
// ----------------------------------------------------------------------------
`default_nettype none

module range_sensor_noise_model_core #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rsnm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  output rsnm_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsnm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rsnm_pkg::*;

  localparam int R2W     = 2 * COORD_WIDTH;
  localparam int ENTRY_W = CLS_W + R2W;
  localparam int LATENCY = COORD_WIDTH + 6;

  qstat_t               q_stat;
  logic                 q_wr, q_pop;
  cls_t                 wr_cls, rd_cls;
  logic [R2W-1:0]       wr_r2, rd_r2;
  logic [ENTRY_W-1:0]   rd_entry;

  // intake and classification
  rsnm_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_wr      (q_wr),
    .q_cls     (wr_cls),
    .q_r2      (wr_r2)
  );

  // decoupling queue
  rsnm_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data ({wr_cls, wr_r2}),
    .rd_en   (q_pop),
    .rd_data (rd_entry),
    .stat    (q_stat)
  );

  assign rd_cls = cls_t'(rd_entry[ENTRY_W-1 -: CLS_W]);
  assign rd_r2  = rd_entry[R2W-1:0];

  // noise evaluation
  rsnm_back #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_cls     (rd_cls),
    .q_r2      (rd_r2),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sv/rsnm_front.sv
// ----------------------------------------------------------------------------
// rsnm_front
// config registers, item intake, classification and squared norm
// ----------------------------------------------------------------------------
`default_nettype none

module rsnm_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  rsnm_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rsnm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsnm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rsnm_pkg::qstat_t                    q_stat,
  output logic                                q_wr,
  output rsnm_pkg::cls_t                      q_cls,
  output logic [2*COORD_WIDTH-1:0]            q_r2
);
  import rsnm_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int R2W = 2 * COORD_WIDTH;

  // magnitude of the sign-extended low coordinate bits
  function automatic logic [CW-1:0] mag(input logic [31:0] raw);
    logic [CW-1:0] v;
    v = raw[CW-1:0];
    return v[CW-1] ? ((~v) + {{(CW-1){1'b0}}, 1'b1}) : v;
  endfunction

  logic [ST_W-1:0]   sensor_type_r;
  logic [DIMS_W-1:0] point_dims_r;
  logic              accept;

  logic              s1_v_r;
  cls_t              s1_cls_r;
  logic [CW-1:0]     s1_mx_r, s1_my_r, s1_mz_r;

  logic              s2_v_r;
  cls_t              s2_cls_r;
  logic [R2W-1:0]    s2_sx_r, s2_sy_r, s2_sz_r;

  logic [R2W-1:0]    sq_x, sq_y, sq_z;
  logic [QLVL_W:0]   occ;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  // room check: queue level plus items still in the front stages
  assign occ    = {1'b0, q_stat.level} + (QLVL_W+1)'(s1_v_r) + (QLVL_W+1)'(s2_v_r);
  assign busy   = !rst_n || (occ >= (QLVL_W+1)'(QDEPTH));
  assign accept = start && !busy;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_type_r <= ST_RESET;
      point_dims_r  <= DIMS_RESET;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SENSOR_TYPE: sensor_type_r <= cfg_data[ST_W-1:0];
          REG_POINT_DIMS:  point_dims_r  <= cfg_data[DIMS_W-1:0];
          default: ;
        endcase
      end
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  // stage 1: magnitudes and class, z dropped in 2d mode
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls_r <= classify(sensor_type_r);
      s1_mx_r  <= mag(in_data.x_coord);
      s1_my_r  <= mag(in_data.y_coord);
      s1_mz_r  <= (point_dims_r == DIMS_2D) ? '0 : mag(in_data.z_coord);
    end
  end

  // stage 2: squares
  assign sq_x = s1_mx_r * s1_mx_r;
  assign sq_y = s1_my_r * s1_my_r;
  assign sq_z = s1_mz_r * s1_mz_r;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_cls_r <= s1_cls_r;
      s2_sx_r  <= sq_x;
      s2_sy_r  <= sq_y;
      s2_sz_r  <= sq_z;
    end
  end

  // squared norm into the queue, never wraps
  assign q_wr  = s2_v_r;
  assign q_cls = s2_cls_r;
  assign q_r2  = s2_sx_r + s2_sy_r + s2_sz_r;

endmodule

`default_nettype wire

### sv/rsnm_queue.sv
// ----------------------------------------------------------------------------
// rsnm_queue
// small register fifo between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module rsnm_queue #(
  parameter int WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  output logic [WIDTH-1:0]  rd_data,
  output rsnm_pkg::qstat_t  stat
);
  import rsnm_pkg::*;

  logic [WIDTH-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QLVL_W-1:0] level_r, level_nxt;

  assign level_nxt  = level_r + QLVL_W'(wr_en) - QLVL_W'(rd_en);
  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      level_r <= level_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

### sv/rsnm_back.sv
// ----------------------------------------------------------------------------
// rsnm_back
// pipelined square root, laser line fit and depth camera quadratic
// ----------------------------------------------------------------------------
`default_nettype none

module rsnm_back #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rsnm_pkg::qstat_t             q_stat,
  input  rsnm_pkg::cls_t               q_cls,
  input  logic [2*COORD_WIDTH-1:0]     q_r2,
  output logic                         q_pop,
  output logic                         out_valid,
  output rsnm_pkg::out_item_t          out_data
);
  import rsnm_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int R2W    = 2 * COORD_WIDTH;
  localparam int REM_W  = COORD_WIDTH + 1;
  localparam int TRY_W  = COORD_WIDTH + 3;
  localparam int PROD_W = COORD_WIDTH + ANG_W;
  localparam int PL_W   = 32 + DCOEF_W;

  typedef struct packed {
    cls_t             cls;
    logic [R2W-1:0]   n;
    logic [REM_W-1:0] rem;
    logic [CW-1:0]    root;
  } sq_t;

  logic             sq_v_r [CW];
  sq_t              sq_r   [CW];

  logic [63:0]      r2_64;
  logic [PL_W-1:0]  plo_r, phi_r;
  logic [63:0]      mid_r, rnd_d;
  out_item_t        dep_w;
  out_item_t        dep_r [2:CW-1];

  logic             l1_v_r;
  cls_t             l1_cls_r;
  logic [PROD_W-1:0] l1_prod_r;
  out_item_t        l1_dep_r;

  logic             l2_v_r;
  cls_t             l2_cls_r;
  logic [63:0]      l2_val_r;
  out_item_t        l2_dep_r;

  logic signed [63:0] lin_w, floor_w;
  logic [63:0]      rnd_l;
  out_item_t        res_w;

  logic             out_v_r;
  out_item_t        out_data_r;

  // the back never stalls, so the queue head is taken whenever present
  assign q_pop = !q_stat.empty;

  // square root, one result bit per stage
  for (genvar k = 0; k < CW; k++) begin : g_sq
    sq_t              in_w, step_w;
    logic             in_v;
    logic [TRY_W-1:0] rem2, trial;

    if (k == 0) begin : g_head
      assign in_v = q_pop;
      assign in_w = '{cls: q_cls, n: q_r2, rem: '0, root: '0};
    end else begin : g_tail
      assign in_v = sq_v_r[k-1];
      assign in_w = sq_r[k-1];
    end

    always_comb begin
      rem2       = {in_w.rem, in_w.n[R2W-1 -: 2]};
      trial      = {1'b0, in_w.root, 2'b01};
      step_w.cls = in_w.cls;
      step_w.n   = {in_w.n[R2W-3:0], 2'b00};
      if (rem2 >= trial) begin
        step_w.rem  = REM_W'(rem2 - trial);
        step_w.root = {in_w.root[CW-2:0], 1'b1};
      end else begin
        step_w.rem  = REM_W'(rem2);
        step_w.root = {in_w.root[CW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else begin
        sq_v_r[k] <= in_v;
      end
    end

    always_ff @(posedge clk) begin
      sq_r[k] <= step_w;
    end
  end

  // depth lane runs beside the root stages: partial products, sum, round
  assign r2_64 = 64'(q_r2);

  always_comb begin
    rnd_d             = mid_r + (64'd1 << (FRAC_BITS - 1));
    dep_w.saturated   = |rnd_d[63:FRAC_BITS+32];
    dep_w.noise_value = dep_w.saturated ? '1 : rnd_d[FRAC_BITS+31:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    plo_r    <= r2_64[31:0]  * DEPTH_COEF;
    phi_r    <= r2_64[63:32] * DEPTH_COEF;
    mid_r    <= 64'(plo_r >> 32) + 64'(phi_r);
    dep_r[2] <= dep_w;
    for (int k = 3; k < CW; k++) begin
      dep_r[k] <= dep_r[k-1];
    end
  end

  // laser slope times root
  always_ff @(posedge clk) begin
    l1_cls_r  <= sq_r[CW-1].cls;
    l1_prod_r <= sq_r[CW-1].root * laser_ang(sq_r[CW-1].cls.sel);
    l1_dep_r  <= dep_r[CW-1];
  end

  // offset and floor at full scale
  always_comb begin
    lin_w   = $signed(64'(l1_prod_r)) + (64'(laser_cst(l1_cls_r.sel)) <<< FRAC_BITS);
    floor_w = $signed(64'(laser_min(l1_cls_r.sel))) <<< FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    l2_cls_r <= l1_cls_r;
    l2_val_r <= (lin_w > floor_w) ? lin_w : floor_w;
    l2_dep_r <= l1_dep_r;
  end

  // round to output scale and pick the model; laser values stay below 2^31
  always_comb begin
    rnd_l = l2_val_r + (64'd1 << 31);
    if (l2_cls_r.is_depth) begin
      res_w = l2_dep_r;
    end else if (l2_cls_r.is_laser) begin
      res_w.noise_value = rnd_l[63:32];
      res_w.saturated   = 1'b0;
    end else begin
      res_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res_w;
  end

  // valid chain through the tail stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_v_r  <= 1'b0;
      l2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      l1_v_r  <= sq_v_r[CW-1];
      l2_v_r  <= l1_v_r;
      out_v_r <= l2_v_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### sv/rsnm_checker.sv
// ----------------------------------------------------------------------------
// rsnm_checker
// port-level timing and result checks, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_sensor_noise_model_core_assert.svh"

module rsnm_checker #(
  parameter int LATENCY = 38
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input rsnm_pkg::out_item_t  out_data
);

  // every accepted point is followed by its result strobe
  `RSNM_ASSERT_IMP(a_lat_fwd, start && !busy, ##LATENCY out_valid)

  // no result without a matching transfer in
  `RSNM_ASSERT_IMP(a_lat_back, out_valid, $past(start && !busy, LATENCY))

  // a saturated result carries the clamp value
  `RSNM_ASSERT_IMP(a_sat_clamp, out_valid && out_data.saturated, out_data.noise_value == 32'hFFFFFFFF)

  // the back end drains the queue each cycle, so busy never rises
  `RSNM_ASSERT_NXT(a_no_busy, 1'b1, !busy)

endmodule

bind range_sensor_noise_model_core rsnm_checker #(
  .LATENCY (LATENCY)
) u_rsnm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

### verif/rsnm_noise_checker.sv
// ----------------------------------------------------------------------------
// rsnm_noise_checker
// watches the point, result and register channels of the range noise model,
// predicts each noise value from the point and the current settings, and
// compares the results in order as they come out
// ----------------------------------------------------------------------------
module rsnm_noise_checker
  import rsnm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC        = 16;
  // 0.001425 scaled by 2^32
  localparam logic [63:0] DEPTH_SCALE = 64'd6120328;

  logic [ST_W-1:0]   model_sel;
  logic [DIMS_W-1:0] dims_sel;
  out_item_t         noise_expected_q[$];

  // absolute value of a signed coordinate
  function automatic logic [63:0] coord_mag(input logic signed [31:0] c);
    logic [63:0] v;
    v = {{32{c[31]}}, c};
    return c[31] ? -v : v;
  endfunction

  // floor of the square root, one result bit per step
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = n;
    res = '0;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // expected noise of one point under the given model and dimension setting
  function automatic out_item_t predict_noise(input in_item_t pt,
                                              input logic [ST_W-1:0] stype,
                                              input logic [DIMS_W-1:0] dims);
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] az;
    logic [63:0] r2;
    logic [63:0] prod_lo;
    logic [63:0] mid;
    logic [63:0] q;
    longint      floor_c;
    longint      slope_c;
    longint      offs_c;
    longint      lin;
    longint      floor_v;
    out_item_t   res;
    ax = coord_mag(pt.x_coord);
    ay = coord_mag(pt.y_coord);
    az = coord_mag(pt.z_coord);
    r2 = ax * ax + ay * ay;
    if (dims != DIMS_2D) r2 = r2 + az * az;
    q       = '0;
    floor_c = 0;
    slope_c = 0;
    offs_c  = 0;
    case (stype)
      ST_DEPTH: begin
        // quadratic in range, product split to stay within 64 bits
        prod_lo = {32'b0, r2[31:0]} * DEPTH_SCALE;
        mid     = (prod_lo >> 32) + (r2 >> 32) * DEPTH_SCALE;
        q       = (mid + (64'd1 << (FRAC - 1))) >> FRAC;
      end
      ST_LASER0, ST_LASER1, ST_LASER2, ST_LASER4: begin
        // minimum radius, beam angle and beam offset, scaled by 2^32
        case (stype)
          ST_LASER0: begin
            floor_c = 51539608;  slope_c = 29205778; offs_c = 3435974;
          end
          ST_LASER1: begin
            floor_c = 120259084; slope_c = 5583457;  offs_c = 429497;
          end
          ST_LASER2: begin
            floor_c = 77309411;  slope_c = 2576980;  offs_c = 6442451;
          end
          default: begin
            floor_c = 17179869;  slope_c = 22763327; offs_c = -39513699;
          end
        endcase
        lin     = slope_c * longint'(root_floor(r2)) + offs_c * (longint'(1) << FRAC);
        floor_v = floor_c * (longint'(1) << FRAC);
        if (lin < floor_v) lin = floor_v;
        q = (64'(lin) + (64'd1 << 31)) >> 32;
      end
      default: q = '0;
    endcase
    res.saturated   = (q > 64'hFFFF_FFFF);
    res.noise_value = res.saturated ? 32'hFFFF_FFFF : q[31:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      model_sel  = ST_RESET;
      dims_sel   = DIMS_RESET;
      mismatches = 0;
      noise_expected_q.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_valid) begin
        if (noise_expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: noise %h sat %b",
                   $time, out_data.noise_value, out_data.saturated);
        end else begin
          want = noise_expected_q.pop_front();
          if (out_data.noise_value !== want.noise_value) begin
            mismatches++;
            $display("%0t: noise_value expected %h actual %h",
                     $time, want.noise_value, out_data.noise_value);
          end
          if (out_data.saturated !== want.saturated) begin
            mismatches++;
            $display("%0t: saturated expected %b actual %b",
                     $time, want.saturated, out_data.saturated);
          end
        end
      end
      // point transfer, predicted with the settings in force before this edge
      if (start && !busy)
        noise_expected_q.push_back(predict_noise(in_data, model_sel, dims_sel));
      // register transfer, only the low bits are kept
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENSOR_TYPE: model_sel = cfg_data[ST_W-1:0];
          REG_POINT_DIMS:  dims_sel  = cfg_data[DIMS_W-1:0];
          default: ;
        endcase
      end
    end
    pending = noise_expected_q.size();
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives points and register writes into the range noise model with random
// gaps, across all sensor types and dimension settings; the checker predicts
// and compares every result
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsnm_pkg::*;

  localparam int                   RUN_LIMIT   = 200000;
  localparam int                   TAIL_CYCLES = 50;
  localparam int                   PHASES      = 12;
  localparam int                   PHASE_ITEMS = 75;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 4'd9;
  localparam logic signed [31:0]   COORD_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]   COORD_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0]   COORD_ONE   = 32'sh0001_0000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;
  int                    cycles = 0;
  int                    points_sent = 0;

  always #5 clk = ~clk;

  range_sensor_noise_model_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rsnm_noise_checker noise_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // coordinate mix: extremes, full range and short ranges of either sign
  function automatic logic signed [31:0] rand_coord();
    logic signed [31:0] v;
    int                 pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       v = COORD_MAX;
        1:       v = COORD_MIN;
        2:       v = '0;
        default: v = -32'sd1;
      endcase
    end else if (pick < 5) begin
      v = $urandom;
    end else begin
      v = 32'($urandom) >> (31 - $urandom_range(0, 24));
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  // one point transfer, with random gaps before it
  task automatic send_point(input in_item_t pt);
    int idle_pct;
    idle_pct = (points_sent < 300) ? 17 : (points_sent < 600) ? 77 : 0;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (busy);
    points_sent++;
  endtask

  // stop sending and wait for every predicted result to arrive
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] word;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes under the reset settings
    send_point(in_item_t'{32'sd0, 32'sd0, 32'sd0});
    send_point(in_item_t'{COORD_MAX, COORD_MAX, COORD_MAX});
    send_point(in_item_t'{COORD_MIN, COORD_MIN, COORD_MIN});
    send_point(in_item_t'{COORD_MIN, COORD_MAX, 32'sd1});
    send_point(in_item_t'{-32'sd1, -32'sd1, -32'sd1});
    wait_drained();

    // write to an unused index leaves the settings alone
    write_reg(REG_SPARE, $urandom);
    send_point(in_item_t'{COORD_ONE, -COORD_ONE, COORD_ONE});
    wait_drained();

    // every sensor type code, dimension codes in turn, junk in upper bits
    for (int k = 0; k < (1 << ST_W); k++) begin
      word = $urandom;
      word[ST_W-1:0] = k[ST_W-1:0];
      write_reg(REG_SENSOR_TYPE, word);
      word = $urandom;
      word[DIMS_W-1:0] = k[DIMS_W-1:0];
      write_reg(REG_POINT_DIMS, word);
      send_point(in_item_t'{COORD_MIN, COORD_MIN, COORD_MIN});
      send_point(in_item_t'{COORD_ONE, -(COORD_ONE >>> 1), COORD_ONE >>> 2});
      wait_drained();
    end

    // random phases, settings changed only with the pipe empty
    for (int p = 0; p < PHASES; p++) begin
      word = $urandom;
      if (p < (1 << ST_W)) word[ST_W-1:0] = p[ST_W-1:0];
      else word[ST_W-1:0] = ST_W'($urandom_range(ST_LASER0, ST_LASER4));
      write_reg(REG_SENSOR_TYPE, word);
      word = $urandom;
      if (p < 2) word[DIMS_W-1:0] = (p == 0) ? DIMS_2D : DIMS_RESET;
      write_reg(REG_POINT_DIMS, word);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) wait_drained();
        send_point(in_item_t'{rand_coord(), rand_coord(), rand_coord()});
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
